[rtl/mux_control_message_parser_assert.svh]
// Assertion macros shared by the parser RTL.
// Each macro checks a property on the rising edge of clk, ignored during rst.
`ifndef MUX_CONTROL_MESSAGE_PARSER_ASSERT_SVH
`define MUX_CONTROL_MESSAGE_PARSER_ASSERT_SVH

// Same-cycle implication.
`define MCMP_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("mcmp assertion failed");

// Next-cycle implication.
`define MCMP_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("mcmp assertion failed");

`endif

[rtl/mcmp_pkg.sv]
package mcmp_pkg;

  // Number of body bytes kept after the type and length bytes.
  localparam int unsigned BODY_BYTES = 8;

  // Message type codes (bits 7..2 of the type byte).
  localparam logic [5:0] MSG_PN  = 6'h20;
  localparam logic [5:0] MSG_MSC = 6'h38;

  // Credit flag nibble for a command and for a response.
  localparam logic [3:0] CREDIT_CMD = 4'hF;
  localparam logic [3:0] CREDIT_RSP = 4'hE;

  // Shortest body lengths for each supported message.
  localparam logic [6:0] PN_MIN_LEN  = 7'd8;
  localparam logic [6:0] MSC_MIN_LEN = 7'd2;

  // Signal bits kept from the MSC signal byte.
  localparam logic [7:0] V24_MASK = 8'hCE;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SHORT       = 4'd1,
    ST_TYPE_EXT    = 4'd2,
    ST_LEN_EXT     = 4'd3,
    ST_OVERRUN     = 4'd4,
    ST_UNSUPPORTED = 4'd5,
    ST_PN_SHORT    = 4'd6,
    ST_MSC_SHORT   = 4'd7,
    ST_DLCI_EA     = 4'd8
  } status_t;

  // One input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_beat_t;

  // One result beat.
  typedef struct packed {
    logic [3:0]  status;
    logic        cr_bit;
    logic [5:0]  msg_type;
    logic [6:0]  msg_length;
    logic [5:0]  dlci;
    logic        credit_supported;
    logic [5:0]  priority_res;
    logic [15:0] max_frame_size;
    logic [2:0]  credit_init;
    logic [7:0]  v24_signals;
  } result_beat_t;

endpackage

[rtl/mux_control_message_parser.sv]
// Channel  Direction  Handshake                 Payload
// byte     in         byte_valid / byte_stall     mcmp_pkg::byte_beat_t
// result   out        result_valid / result_stall mcmp_pkg::result_beat_t
//
// One byte is taken per cycle while byte_stall is low; a message's result is
// registered as its last byte is taken: in the output register, or the skid on a stall.
// The decode is one pass of logic from the capture registers to the output register.
// A skid register behind the output register lets bytes keep flowing while a
// result waits; byte_stall rises only when both hold results.
// rst is synchronous and clears the byte count, the header and body capture and
// both result slots.
module mux_control_message_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  mcmp_pkg::byte_beat_t   byte_beat,
  output logic                   result_valid,
  input  logic                   result_stall,
  output mcmp_pkg::result_beat_t result_beat
);

  // Capture state for the message in progress.
  logic [7:0] byte_count;
  logic [7:0] type_byte;
  logic [7:0] length_byte;
  logic [7:0] body_bytes [mcmp_pkg::BODY_BYTES];

  // Skid slot behind the output register.
  logic                   skid_valid;
  mcmp_pkg::result_beat_t skid_beat;

  logic                   byte_take;
  logic                   result_load;
  logic [7:0]             count_next;
  logic [7:0]             type_m;
  logic [7:0]             length_m;
  logic [7:0]             body_m [mcmp_pkg::BODY_BYTES];
  mcmp_pkg::result_beat_t decoded;

  assign byte_stall  = skid_valid;
  assign byte_take   = byte_valid && !skid_valid;
  assign result_load = byte_take && byte_beat.last_byte;

  // Saturating count including the current byte.
  assign count_next = (byte_count == 8'hFF) ? 8'hFF : byte_count + 8'd1;

  // Capture state with the current byte merged in.
  always_comb begin
    type_m   = (byte_count == 8'd0) ? byte_beat.data_byte : type_byte;
    length_m = (byte_count == 8'd1) ? byte_beat.data_byte : length_byte;
    for (int i = 0; i < mcmp_pkg::BODY_BYTES; i++) begin
      body_m[i] = (byte_count == 8'(i + 2)) ? byte_beat.data_byte : body_bytes[i];
    end
  end

  // Header checks, then PN or MSC body decode.
  always_comb begin
    decoded = '0;
    decoded.status = mcmp_pkg::ST_OK;
    priority if (count_next < 8'd2) begin
      decoded.status = mcmp_pkg::ST_SHORT;
    end else if (!type_m[0]) begin
      decoded.status = mcmp_pkg::ST_TYPE_EXT;
    end else if (!length_m[0]) begin
      decoded.status = mcmp_pkg::ST_LEN_EXT;
    end else begin
      decoded.cr_bit     = type_m[1];
      decoded.msg_type   = type_m[7:2];
      decoded.msg_length = length_m[7:1];
      priority if ({1'b0, length_m[7:1]} + 8'd2 > count_next) begin
        decoded.status = mcmp_pkg::ST_OVERRUN;
      end else if (type_m[7:2] == mcmp_pkg::MSG_PN) begin
        if (length_m[7:1] < mcmp_pkg::PN_MIN_LEN) begin
          decoded.status = mcmp_pkg::ST_PN_SHORT;
        end else begin
          decoded.dlci             = body_m[0][5:0];
          decoded.credit_supported = (body_m[1][7:4] ==
            (type_m[1] ? mcmp_pkg::CREDIT_CMD : mcmp_pkg::CREDIT_RSP));
          decoded.priority_res     = body_m[2][5:0];
          decoded.max_frame_size   = {body_m[5], body_m[4]};
          decoded.credit_init      = body_m[7][2:0];
        end
      end else if (type_m[7:2] == mcmp_pkg::MSG_MSC) begin
        priority if (length_m[7:1] < mcmp_pkg::MSC_MIN_LEN) begin
          decoded.status = mcmp_pkg::ST_MSC_SHORT;
        end else if (!body_m[0][0]) begin
          decoded.status = mcmp_pkg::ST_DLCI_EA;
        end else begin
          decoded.dlci        = body_m[0][7:2];
          decoded.v24_signals = body_m[1] & mcmp_pkg::V24_MASK;
        end
      end else begin
        decoded.status = mcmp_pkg::ST_UNSUPPORTED;
      end
    end
  end

  // Byte capture; everything clears after the last byte of a message.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      type_byte   <= '0;
      length_byte <= '0;
      for (int i = 0; i < mcmp_pkg::BODY_BYTES; i++) begin
        body_bytes[i] <= '0;
      end
    end else if (byte_take) begin
      if (byte_beat.last_byte) begin
        byte_count  <= '0;
        type_byte   <= '0;
        length_byte <= '0;
        for (int i = 0; i < mcmp_pkg::BODY_BYTES; i++) begin
          body_bytes[i] <= '0;
        end
      end else begin
        byte_count  <= count_next;
        type_byte   <= type_m;
        length_byte <= length_m;
        for (int i = 0; i < mcmp_pkg::BODY_BYTES; i++) begin
          body_bytes[i] <= body_m[i];
        end
      end
    end
  end

  // Output register with a skid slot behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= result_load;
      end
    end else if (result_load) begin
      skid_valid <= 1'b1;
    end
  end

  // Result payloads follow the valid flags above.
  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_beat <= skid_beat;
      end else if (result_load) begin
        result_beat <= decoded;
      end
    end else if (result_load) begin
      skid_beat <= decoded;
    end
  end

  `include "mux_control_message_parser_assert.svh"

  // The skid slot is only used while the output register is full.
  `MCMP_ASSERT_NOW(a_skid_behind_out, skid_valid, result_valid)

  // A byte that is not last never creates a result on an empty output.
  `MCMP_ASSERT_NEXT(a_no_spurious_result,
    byte_take && !byte_beat.last_byte && !result_valid, !result_valid)

  // The last byte restarts the byte count.
  `MCMP_ASSERT_NEXT(a_count_restart, result_load, byte_count == 8'd0)

  // Results carry only defined status codes.
  `MCMP_ASSERT_NOW(a_status_range, result_valid,
    result_beat.status <= mcmp_pkg::ST_DLCI_EA)

endmodule

[tb/sv/tb_mux_control_message_parser.sv]
module tb_mux_control_message_parser;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_BYTES  = 525;

  typedef logic [7:0] msg_bytes_t[$];

  // Shapes of generated control messages.
  typedef enum logic [1:0] {
    GEN_PN,
    GEN_MSC,
    GEN_OTHER,
    GEN_NOISE
  } gen_kind_t;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   byte_valid   = 1'b0;
  logic                   byte_stall;
  mcmp_pkg::byte_beat_t   byte_beat    = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  mcmp_pkg::result_beat_t result_beat;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int fail_count    = 0;
  int bytes_sent    = 0;
  int quiet_cycles  = 0;

  // Decoder state kept alongside the block: byte count, header and body capture.
  logic [7:0] msg_count;
  logic [7:0] msg_type_byte;
  logic [7:0] msg_length_byte;
  logic [7:0] msg_body [mcmp_pkg::BODY_BYTES];

  // Decoded results still waiting for their beat on the result channel.
  mcmp_pkg::result_beat_t pending_results[$];
  mcmp_pkg::result_beat_t wanted;

  mux_control_message_parser dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_beat    (byte_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Start a fresh message.
  function automatic void clear_message();
    msg_count       = '0;
    msg_type_byte   = '0;
    msg_length_byte = '0;
    foreach (msg_body[i]) msg_body[i] = '0;
  endfunction

  // Capture one byte and, on the last byte of a message, decode the result.
  function automatic bit decode_byte(input mcmp_pkg::byte_beat_t b,
                                     output mcmp_pkg::result_beat_t r);
    int pos;
    pos = msg_count;
    r   = '0;
    if (pos == 0) begin
      msg_type_byte = b.data_byte;
    end else if (pos == 1) begin
      msg_length_byte = b.data_byte;
    end else if (pos - 2 < mcmp_pkg::BODY_BYTES) begin
      msg_body[pos - 2] = b.data_byte;
    end
    msg_count = (pos < 255) ? 8'(pos + 1) : 8'd255;
    if (!b.last_byte) return 1'b0;

    if (msg_count < 2) begin
      r.status = mcmp_pkg::ST_SHORT;
    end else if (!msg_type_byte[0]) begin
      r.status = mcmp_pkg::ST_TYPE_EXT;
    end else if (!msg_length_byte[0]) begin
      r.status = mcmp_pkg::ST_LEN_EXT;
    end else begin
      r.cr_bit     = msg_type_byte[1];
      r.msg_type   = msg_type_byte[7:2];
      r.msg_length = msg_length_byte[7:1];
      if (int'(r.msg_length) + 2 > int'(msg_count)) begin
        r.status = mcmp_pkg::ST_OVERRUN;
      end else if (r.msg_type == mcmp_pkg::MSG_PN) begin
        if (r.msg_length < mcmp_pkg::PN_MIN_LEN) begin
          r.status = mcmp_pkg::ST_PN_SHORT;
        end else begin
          r.dlci             = msg_body[0][5:0];
          r.credit_supported = r.cr_bit ? (msg_body[1][7:4] == mcmp_pkg::CREDIT_CMD)
                                        : (msg_body[1][7:4] == mcmp_pkg::CREDIT_RSP);
          r.priority_res     = msg_body[2][5:0];
          r.max_frame_size   = {msg_body[5], msg_body[4]};
          r.credit_init      = msg_body[7][2:0];
        end
      end else if (r.msg_type == mcmp_pkg::MSG_MSC) begin
        if (r.msg_length < mcmp_pkg::MSC_MIN_LEN) begin
          r.status = mcmp_pkg::ST_MSC_SHORT;
        end else if (!msg_body[0][0]) begin
          r.status = mcmp_pkg::ST_DLCI_EA;
        end else begin
          r.dlci        = msg_body[0][7:2];
          r.v24_signals = msg_body[1] & mcmp_pkg::V24_MASK;
        end
      end else begin
        r.status = mcmp_pkg::ST_UNSUPPORTED;
      end
    end
    clear_message();
    return 1'b1;
  endfunction

  // Offer one byte beat after a random gap and hold it until it is taken.
  task automatic send_byte(input logic [7:0] d, input logic last);
    mcmp_pkg::byte_beat_t   b;
    mcmp_pkg::result_beat_t r;
    b.data_byte = d;
    b.last_byte = last;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_beat  <= b;
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
    if (decode_byte(b, r)) pending_results.push_back(r);
  endtask

  task automatic send_message(input msg_bytes_t m);
    foreach (m[i]) send_byte(m[i], i == m.size() - 1);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Compare every accepted result beat with the oldest decoded result.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat arrived with no message pending");
        fail_count++;
      end else begin
        wanted = pending_results.pop_front();
        check_field("status", wanted.status, result_beat.status);
        check_field("cr_bit", wanted.cr_bit, result_beat.cr_bit);
        check_field("msg_type", wanted.msg_type, result_beat.msg_type);
        check_field("msg_length", wanted.msg_length, result_beat.msg_length);
        check_field("dlci", wanted.dlci, result_beat.dlci);
        check_field("credit_supported", wanted.credit_supported,
                    result_beat.credit_supported);
        check_field("priority_res", wanted.priority_res, result_beat.priority_res);
        check_field("max_frame_size", wanted.max_frame_size,
                    result_beat.max_frame_size);
        check_field("credit_init", wanted.credit_init, result_beat.credit_init);
        check_field("v24_signals", wanted.v24_signals, result_beat.v24_signals);
      end
    end
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Stop the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Buffers rejected before the body is looked at.
  task automatic test_header_errors();
    send_message('{8'hFF});              // one byte only
    send_message('{8'h80, 8'h03});       // type extension bit clear
    send_message('{8'h81, 8'h02});       // length extension bit clear
    send_message('{8'h83, 8'h05});       // declared body longer than buffer
    send_message('{8'h05, 8'h01});       // type that is neither PN nor MSC
  endtask

  // Parameter negotiation: body too short, then a full body at field extremes.
  task automatic test_pn_messages();
    send_message('{8'h83, 8'h01});
    send_message('{8'h83, 8'h11, 8'hFF, 8'hF0, 8'h3F, 8'h00,
                   8'hFF, 8'hFF, 8'h00, 8'h07});
  endtask

  // Modem status: body too short, DLCI extension bit clear, then a good one.
  task automatic test_msc_messages();
    send_message('{8'hE3, 8'h03});
    send_message('{8'hE1, 8'h05, 8'h08, 8'hFF});
    send_message('{8'hE3, 8'h05, 8'hFF, 8'hFF});
  endtask

  // A buffer past 255 bytes: the count must saturate, not wrap.
  task automatic test_long_buffer();
    msg_bytes_t m;
    m = '{8'h83, 8'hFF};
    repeat (298) m.push_back(8'($urandom_range(255)));
    send_message(m);
  endtask

  // Mostly well-formed PN and MSC messages with random content, plus other types and noise.
  task automatic test_random_traffic(input int target_bytes);
    msg_bytes_t m;
    gen_kind_t  kind;
    int         first_byte;
    int         pick;
    int         mlen;
    int         body_len;
    logic [7:0] type_b;
    logic [7:0] len_b;
    logic [7:0] bb;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < target_bytes) begin
      pick = $urandom_range(99);
      if (pick < 40) kind = GEN_PN;
      else if (pick < 70) kind = GEN_MSC;
      else if (pick < 85) kind = GEN_OTHER;
      else kind = GEN_NOISE;
      m = {};

      if (kind == GEN_NOISE) begin
        repeat ($urandom_range(1, 12)) m.push_back(8'($urandom_range(255)));
      end else begin
        type_b = 8'($urandom_range(255));
        if (kind == GEN_PN) begin
          type_b[7:2] = mcmp_pkg::MSG_PN;
          mlen = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(6, 12);
        end else if (kind == GEN_MSC) begin
          type_b[7:2] = mcmp_pkg::MSG_MSC;
          mlen = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 5);
        end else begin
          mlen = $urandom_range(15);
        end
        type_b[0] = ($urandom_range(19) != 0);
        len_b     = {7'(mlen), 1'b1};
        if ($urandom_range(19) == 0) len_b[0] = 1'b0;

        // Usually the body fits the declared length; sometimes it falls short
        // or runs far past the capture window.
        body_len = mlen + $urandom_range(2);
        if ($urandom_range(9) == 0) body_len = $urandom_range(mlen);
        if ($urandom_range(149) == 0) body_len = $urandom_range(254, 300);

        m.push_back(type_b);
        m.push_back(len_b);
        for (int i = 0; i < body_len; i++) begin
          bb = 8'($urandom_range(255));
          if (kind == GEN_PN && i == 1) begin
            pick = $urandom_range(2);
            if (pick == 0) bb[7:4] = mcmp_pkg::CREDIT_CMD;
            else if (pick == 1) bb[7:4] = mcmp_pkg::CREDIT_RSP;
          end
          if (kind == GEN_MSC && i == 0 && $urandom_range(9) != 0) bb[0] = 1'b1;
          m.push_back(bb);
        end
      end
      send_message(m);
    end
  endtask

  initial begin
    clear_message();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 38;
    stall_pct     = 88;
    test_header_errors();
    test_pn_messages();
    test_msc_messages();
    test_long_buffer();
    test_random_traffic(PHASE_BYTES);

    send_idle_pct = 88;
    stall_pct     = 38;
    test_random_traffic(PHASE_BYTES);

    send_idle_pct = 0;
    stall_pct     = 0;
    test_random_traffic(PHASE_BYTES);

    byte_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
